@@ src/sbtpl_pkg.sv @@
package sbtpl_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned CoordW        = 32;
  localparam int unsigned TagW          = 16;

  localparam logic ActInsert = 1'b0;
  localparam logic ActLookup = 1'b1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNotFound = 2'd1,
    StatusFull     = 2'd2
  } status_e;

  typedef struct packed {
    logic [CoordW-1:0] lx;
    logic [CoordW-1:0] ly;
    logic [CoordW-1:0] lz;
    logic [CoordW-1:0] hx;
    logic [CoordW-1:0] hy;
    logic [CoordW-1:0] hz;
    logic [TagW-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } point_t;

  // search result carried along the chain
  typedef struct packed {
    logic            found;
    logic [TagW-1:0] tag;
  } carry_t;

  // per-cycle control shared by all cells
  typedef struct packed {
    logic ins;
    logic look;
  } cell_ctl_t;

endpackage

@@ src/sbtpl_cell.sv @@
module sbtpl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbtpl_pkg::cell_ctl_t ctl_i,
  input  sbtpl_pkg::entry_t   new_i,
  input  sbtpl_pkg::point_t   pt_i,
  input  logic                valid_i,
  input  logic                prev_valid_i,
  input  logic                prev_gt_i,
  input  sbtpl_pkg::entry_t   prev_entry_i,
  output sbtpl_pkg::entry_t   entry_o,
  output logic                gt_o,
  input  logic                tok_i,
  input  sbtpl_pkg::carry_t   car_i,
  output logic                tok_o,
  output sbtpl_pkg::carry_t   car_o
);

  sbtpl_pkg::entry_t entry_q, entry_d;
  sbtpl_pkg::carry_t car_q, car_d;
  logic              hit_q, hit_d;
  logic              tok_q;
  logic              take_new;

  assign gt_o     = valid_i && (entry_q.lx > new_i.lx);
  // open the slot: either first larger entry or first empty slot
  assign take_new = !prev_gt_i && (gt_o || (!valid_i && prev_valid_i));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        entry_d = prev_entry_i;
      end else if (take_new) begin
        entry_d = new_i;
      end
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctl_i.look) begin
      hit_d = valid_i
           && (pt_i.x >= entry_q.lx) && (pt_i.x < entry_q.hx)
           && (pt_i.y >= entry_q.ly) && (pt_i.y < entry_q.hy)
           && (pt_i.z >= entry_q.lz) && (pt_i.z < entry_q.hz);
    end
  end

  // lower cells win: keep an earlier hit, else offer our own
  always_comb begin
    car_d = car_q;
    if (tok_i) begin
      if (car_i.found) begin
        car_d = car_i;
      end else if (hit_q) begin
        car_d.found = 1'b1;
        car_d.tag   = entry_q.tag;
      end else begin
        car_d = car_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
    car_q   <= car_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign entry_o = entry_q;
  assign tok_o   = tok_q;
  assign car_o   = car_q;

endmodule

@@ src/sorted_box_table_point_lookup_top.sv @@
// Insert: result strobed in the cycle after the request; one insert per cycle
//   while no lookup holds busy_o. Lookup: the request is registered in
//   look_q, then the search token walks the cell chain one cell per cycle
//   and the result is strobed as it leaves the last cell, ending busy_o.
// Reset clears the fill count and all control; table contents stay unknown.
// Results cannot be stalled by the receiver.
module sorted_box_table_point_lookup_top #(
  parameter int unsigned TABLE_DEPTH = sbtpl_pkg::TableDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [31:0] low_x_i,
  input  logic [31:0] low_y_i,
  input  logic [31:0] low_z_i,
  input  logic [31:0] high_x_i,
  input  logic [31:0] high_y_i,
  input  logic [31:0] high_z_i,
  input  logic [15:0] box_tag_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] hit_tag_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            look_q;          // launches the search token into cell 0
  logic            ins_done_q;      // insert result pending on the output
  sbtpl_pkg::status_e ins_status_q;

  // Request handshake and decode.
  logic accept, full, do_ins, do_look;
  assign accept  = start_i && !busy_o;
  assign full    = (cnt_q == CntW'(TABLE_DEPTH));
  assign do_ins  = accept && (action_i == sbtpl_pkg::ActInsert) && !full;
  assign do_look = accept && (action_i == sbtpl_pkg::ActLookup);

  sbtpl_pkg::cell_ctl_t ctl;
  sbtpl_pkg::entry_t    new_entry;
  sbtpl_pkg::point_t    pt;

  assign ctl.ins  = do_ins;
  assign ctl.look = do_look;

  assign new_entry.lx  = low_x_i;
  assign new_entry.ly  = low_y_i;
  assign new_entry.lz  = low_z_i;
  assign new_entry.hx  = high_x_i;
  assign new_entry.hy  = high_y_i;
  assign new_entry.hz  = high_z_i;
  assign new_entry.tag = box_tag_i;
  assign pt.x = point_x_i;
  assign pt.y = point_y_i;
  assign pt.z = point_z_i;

  // Cell chain: each cell hands its entry and "greater than new x" flag up
  // for the sorted shift, and the search token with carry along the row.
  logic              valid [TABLE_DEPTH];
  logic              gt    [TABLE_DEPTH];
  logic              tok   [TABLE_DEPTH];
  sbtpl_pkg::entry_t ent   [TABLE_DEPTH];
  sbtpl_pkg::carry_t car   [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic              prev_valid, prev_gt, tok_in;
    sbtpl_pkg::entry_t prev_entry;
    sbtpl_pkg::carry_t car_in;

    // a slot is occupied when it sits below the fill count
    assign valid[k] = (CntW'(k) < cnt_q);

    if (k == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_gt    = 1'b0;
      assign prev_entry = new_entry;
      assign tok_in     = look_q;
      assign car_in     = '0;
    end else begin : g_body
      assign prev_valid = valid[k-1];
      assign prev_gt    = gt[k-1];
      assign prev_entry = ent[k-1];
      assign tok_in     = tok[k-1];
      assign car_in     = car[k-1];
    end

    sbtpl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_i        (new_entry),
      .pt_i         (pt),
      .valid_i      (valid[k]),
      .prev_valid_i (prev_valid),
      .prev_gt_i    (prev_gt),
      .prev_entry_i (prev_entry),
      .entry_o      (ent[k]),
      .gt_o         (gt[k]),
      .tok_i        (tok_in),
      .car_i        (car_in),
      .tok_o        (tok[k]),
      .car_o        (car[k])
    );
  end

  logic look_done;
  assign look_done = tok[TABLE_DEPTH-1];

  // Advance the fill count on each insert into a non-full table; hold busy
  // through a lookup until the token leaves the last cell.
  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) begin
      cnt_d = cnt_q + CntW'(1);
    end
    busy_d = busy_q;
    if (do_look) begin
      busy_d = 1'b1;
    end else if (look_done) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      busy_q     <= 1'b0;
      look_q     <= 1'b0;
      ins_done_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      busy_q     <= busy_d;
      look_q     <= do_look;
      ins_done_q <= accept && (action_i == sbtpl_pkg::ActInsert);
    end
  end

  always_ff @(posedge clk_i) begin
    ins_status_q <= full ? sbtpl_pkg::StatusFull : sbtpl_pkg::StatusOk;
  end

  assign busy_o = busy_q;

  // Drive the result from the insert register or the end of the chain.
  always_comb begin
    done_o    = ins_done_q || look_done;
    status_o  = sbtpl_pkg::StatusOk;
    hit_tag_o = '0;
    if (ins_done_q) begin
      status_o = ins_status_q;
    end else if (car[TABLE_DEPTH-1].found) begin
      status_o  = sbtpl_pkg::StatusOk;
      hit_tag_o = car[TABLE_DEPTH-1].tag;
    end else begin
      status_o = sbtpl_pkg::StatusNotFound;
    end
  end

  // Insert and lookup results never land in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ins_done_q && look_done))
    else $error("insert and lookup results collide");

  // Fill count stays within the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // A lookup request holds the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) do_look |=> busy_q)
    else $error("lookup accepted without going busy");

  // An insert into a non-full table grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert did not advance fill count");

  // The result strobe never reports a code outside the status set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == sbtpl_pkg::StatusOk || status_o == sbtpl_pkg::StatusNotFound
                || status_o == sbtpl_pkg::StatusFull))
    else $error("bad status code");

endmodule

@@ verif/sorted_box_table_point_lookup_top_tb.sv @@
module sorted_box_table_point_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = sbtpl_pkg::TableDepthDef;

  // One expected answer per accepted request, oldest first.
  typedef struct {
    sbtpl_pkg::status_e         status;
    logic [sbtpl_pkg::TagW-1:0] tag;
  } box_answer_t;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        start_i   = 1'b0;
  logic        action_i  = sbtpl_pkg::ActInsert;
  logic [31:0] low_x_i   = '0;
  logic [31:0] low_y_i   = '0;
  logic [31:0] low_z_i   = '0;
  logic [31:0] high_x_i  = '0;
  logic [31:0] high_y_i  = '0;
  logic [31:0] high_z_i  = '0;
  logic [15:0] box_tag_i = '0;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic [31:0] point_z_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] hit_tag_o;

  // Shadow copy of the table: sorted by lower x, only the first box_count
  // slots are meaningful.
  sbtpl_pkg::entry_t box_table [TableDepth];
  int                box_count  = 0;
  box_answer_t       answer_q [$];
  int                fail_count = 0;
  int                idle_pct   = 0;

  sorted_box_table_point_lookup_top #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .action_i (action_i),
    .low_x_i  (low_x_i),
    .low_y_i  (low_y_i),
    .low_z_i  (low_z_i),
    .high_x_i (high_x_i),
    .high_y_i (high_y_i),
    .high_z_i (high_z_i),
    .box_tag_i(box_tag_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .point_z_i(point_z_i),
    .done_o   (done_o),
    .status_o (status_o),
    .hit_tag_o(hit_tag_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Half-open containment test on one axis: lo <= p < hi.
  function automatic bit in_span(logic [31:0] p, logic [31:0] lo, logic [31:0] hi);
    return (p >= lo) && (p < hi);
  endfunction

  // Apply one accepted request to the shadow table and return the answer
  // the block must give for it.
  function automatic box_answer_t resolve_request(logic act, sbtpl_pkg::entry_t box,
                                                  sbtpl_pkg::point_t pt);
    box_answer_t ans;
    int          pos;
    ans.status = sbtpl_pkg::StatusOk;
    ans.tag    = '0;
    if (act == sbtpl_pkg::ActInsert) begin
      if (box_count >= TableDepth) begin
        // Full table: drop the box, leave the table untouched.
        ans.status = sbtpl_pkg::StatusFull;
      end else begin
        // Shift every strictly larger lower x up by one; equal lower x
        // stays in front of the new box.
        pos = box_count;
        while (pos > 0 && box_table[pos-1].lx > box.lx) begin
          box_table[pos] = box_table[pos-1];
          pos--;
        end
        box_table[pos] = box;
        box_count++;
      end
    end else begin
      ans.status = sbtpl_pkg::StatusNotFound;
      // The lowest slot that holds the point wins when boxes overlap.
      for (int i = 0; i < box_count; i++) begin
        if (in_span(pt.x, box_table[i].lx, box_table[i].hx) &&
            in_span(pt.y, box_table[i].ly, box_table[i].hy) &&
            in_span(pt.z, box_table[i].lz, box_table[i].hz)) begin
          ans.status = sbtpl_pkg::StatusOk;
          ans.tag    = box_table[i].tag;
          break;
        end
      end
    end
    return ans;
  endfunction

  function automatic sbtpl_pkg::entry_t make_box(
      logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
      logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
      logic [15:0] tag);
    sbtpl_pkg::entry_t box;
    box.lx  = lx;
    box.ly  = ly;
    box.lz  = lz;
    box.hx  = hx;
    box.hy  = hy;
    box.hz  = hz;
    box.tag = tag;
    return box;
  endfunction

  function automatic sbtpl_pkg::entry_t random_box();
    return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    16'($urandom_range(0, 16'hFFFF)));
  endfunction

  function automatic sbtpl_pkg::point_t random_point();
    sbtpl_pkg::point_t pt;
    pt.x = $urandom;
    pt.y = $urandom;
    pt.z = $urandom;
    return pt;
  endfunction

  // Pick a coordinate around one axis of a stored box: mostly inside,
  // otherwise right on or just past either bound.
  function automatic logic [31:0] pick_coord(logic [31:0] lo, logic [31:0] hi);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      6: return lo;
      7: return hi - 32'd1;
      8: return hi;
      9: return lo - 32'd1;
      default: begin
        if (lo < hi) return lo + ($urandom % (hi - lo));
        return lo;
      end
    endcase
  endfunction

  // Present one request, hold it until the block takes it, then record the
  // expected answer. Leave start high when the next request follows at once.
  task automatic send_request(logic act, sbtpl_pkg::entry_t box, sbtpl_pkg::point_t pt);
    start_i   <= 1'b1;
    action_i  <= act;
    low_x_i   <= box.lx;
    low_y_i   <= box.ly;
    low_z_i   <= box.lz;
    high_x_i  <= box.hx;
    high_y_i  <= box.hy;
    high_z_i  <= box.hz;
    box_tag_i <= box.tag;
    point_x_i <= pt.x;
    point_y_i <= pt.y;
    point_z_i <= pt.z;
    do @(posedge clk_i); while (busy_o);
    answer_q.push_back(resolve_request(act, box, pt));
    if ($urandom_range(0, 99) < idle_pct) begin
      // Drop start for a while; long gaps outlast a whole lookup.
      start_i <= 1'b0;
      repeat ($urandom_range(1, TableDepth + 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_lookup(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    sbtpl_pkg::point_t pt;
    pt.x = x;
    pt.y = y;
    pt.z = z;
    send_request(sbtpl_pkg::ActLookup, make_box('0, '0, '0, '0, '0, '0, '0), pt);
  endtask

  task automatic send_insert(sbtpl_pkg::entry_t box);
    send_request(sbtpl_pkg::ActInsert, box, sbtpl_pkg::point_t'('0));
  endtask

  // A lookup on a table that holds nothing, with all point fields at zero.
  task automatic test_empty_lookup();
    send_lookup(32'h0, 32'h0, 32'h0);
  endtask

  // Build a small table whose insert order forces shifts, an equal lower x,
  // an empty box, an inverted box and a box at the top of the range.
  task automatic test_sorted_insert();
    // A goes into the empty table, B shifts it up, C ties A on lower x.
    send_insert(make_box(32'h1000, 32'h0, 32'h0, 32'h2000, 32'h8000_0000, 32'hFFFF_FFFF,
                         16'hFFFF));
    send_insert(make_box(32'h0, 32'd10, 32'd10, 32'h100, 32'd20, 32'd20, 16'h0001));
    send_insert(make_box(32'h1000, 32'h0, 32'h0, 32'h3000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         16'hA5A5));
    send_insert(make_box(32'hFFFF_FFF0, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000));
    // Empty x range, then inverted x range: both land below the top box.
    send_insert(make_box(32'h5000, 32'h0, 32'h0, 32'h5000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         16'h5A5A));
    send_insert(make_box(32'h7000, 32'h0, 32'h0, 32'h6000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         16'h0F0F));
  endtask

  // Probe the bounds of the boxes placed above.
  task automatic test_boundary_lookups();
    send_lookup(32'h0, 32'd10, 32'd10);                    // lower corner of B
    send_lookup(32'hFF, 32'd19, 32'd19);                   // last point of B
    send_lookup(32'h100, 32'd15, 32'd15);                  // upper x is exclusive
    send_lookup(32'h1800, 32'd5, 32'd5);                   // A and C overlap: A wins
    send_lookup(32'h1800, 32'h9000_0000, 32'd5);           // only C holds this y
    send_lookup(32'hFFF, 32'd5, 32'd5);                    // just below A
    send_lookup(32'h5000, 32'd5, 32'd5);                   // empty box never hits
    send_lookup(32'h6800, 32'd5, 32'd5);                   // inverted box never hits
    send_lookup(32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE); // hit with tag zero
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // top point is outside
  endtask

  // Fill the rest of the table with disjoint boxes in shuffled x windows,
  // then try to insert past capacity.
  task automatic test_table_overflow();
    int                window_q [$];
    int                idx;
    logic [31:0]       base;
    sbtpl_pkg::entry_t box;
    for (int k = 0; k < 14; k++) window_q.push_back(k);
    while (box_count < TableDepth) begin
      idx  = $urandom_range(0, window_q.size() - 1);
      base = 32'(window_q[idx] + 1) << 28;
      window_q.delete(idx);
      box    = random_box();
      box.lx = base + $urandom_range(0, 32'h07FF_FFFF);
      box.hx = box.lx + $urandom_range(1, 32'h07FF_FFFF);
      box.ly = $urandom_range(0, 32'hEFFF_FFFF);
      box.hy = box.ly + $urandom_range(1, 32'h0FFF_FFFF);
      box.lz = $urandom_range(0, 32'hEFFF_FFFF);
      box.hz = box.lz + $urandom_range(1, 32'h0FFF_FFFF);
      send_insert(box);
    end
    send_insert(make_box('1, '1, '1, '1, '1, '1, '1));
    send_insert(random_box());
  endtask

  // Mostly lookups aimed at stored boxes, plus random points and inserts
  // that the full table must refuse. Unused fields carry random values.
  task automatic test_random_traffic(int count, int pct);
    logic              act;
    sbtpl_pkg::entry_t box;
    sbtpl_pkg::entry_t target;
    sbtpl_pkg::point_t pt;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      box = random_box();
      pt  = random_point();
      if ($urandom_range(0, 99) < 20) begin
        act = sbtpl_pkg::ActInsert;
      end else begin
        act = sbtpl_pkg::ActLookup;
        if (box_count != 0 && $urandom_range(0, 99) < 65) begin
          target = box_table[$urandom_range(0, box_count - 1)];
          pt.x   = pick_coord(target.lx, target.hx);
          pt.y   = pick_coord(target.ly, target.hy);
          pt.z   = pick_coord(target.lz, target.hz);
        end
      end
      send_request(act, box, pt);
    end
  endtask

  // Take every strobed result and match it against the oldest expectation.
  always @(posedge clk_i) begin
    box_answer_t want;
    if (rst_ni && done_o) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result: status %0d hit_tag %h", status_o, hit_tag_o);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (hit_tag_o !== want.tag) begin
          $error("hit_tag: expected %h, got %h", want.tag, hit_tag_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // Hold reset from the start, then release it on a clock edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part runs under the first idling setting.
    idle_pct = 21;
    test_empty_lookup();
    test_sorted_insert();
    test_boundary_lookups();
    test_table_overflow();

    // Random part: sender idles often, then very often, then never.
    test_random_traffic(700, 21);
    test_random_traffic(700, 49);
    test_random_traffic(600, 0);
    start_i <= 1'b0;

    // Drain outstanding answers, then watch a lookup's worth of cycles for
    // any stray strobe.
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS sorted_box_table_point_lookup_top");
    end else begin
      $display("FAIL sorted_box_table_point_lookup_top");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("FAIL sorted_box_table_point_lookup_top");
    $finish;
  end

endmodule

@@ sim.f @@
src/sbtpl_pkg.sv
src/sbtpl_cell.sv
src/sorted_box_table_point_lookup_top.sv
verif/sorted_box_table_point_lookup_top_tb.sv
